// ===== rtl/npms_pkg.sv =====
// ----------------------------------------------------------------------------
// npms_pkg
// shared constants and types for the next prime power multiple sieve
// ----------------------------------------------------------------------------
package npms_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 1024;
    localparam int unsigned WORD_W          = 64;
    localparam int unsigned ACTIVE_W        = 10;

    localparam logic [WORD_W-1:0] MAX_WORD = '1;

    localparam logic REG_START_VALUE  = 1'b0;
    localparam logic REG_FIRST_ACTIVE = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD_DIV,
        ST_LOAD_MUL,
        ST_LOAD_CHK,
        ST_LOAD_WRITE,
        ST_LOAD_RD,
        ST_LOAD_CMP,
        ST_Q_RD,
        ST_Q_CMP,
        ST_Q_DIV,
        ST_Q_MUL,
        ST_Q_ADD,
        ST_Q_WRITE,
        ST_Q_RDN,
        ST_Q_CMPN,
        ST_DONE
    } state_t;

    // request to and status from the divider
    typedef struct packed {
        logic            start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic            busy;
        logic            done;
        logic [WORD_W-1:0] quotient;
        logic [WORD_W-1:0] remainder;
    } div_rsp_t;

endpackage

// ===== rtl/npms_divider.sv =====
// ----------------------------------------------------------------------------
// npms_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module npms_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  npms_pkg::div_req_t req,
    output npms_pkg::div_rsp_t rsp
);
    import npms_pkg::*;

    logic [WORD_W-1:0] quot_reg, quot_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] dsr_reg, dsr_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W:0]   trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[WORD_W-1]} - {1'b0, dsr_reg};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 7'(WORD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial[WORD_W])
            begin
                rem_next  = {rem_reg[WORD_W-2:0], quot_reg[WORD_W-1]};
                quot_next = {quot_reg[WORD_W-2:0], 1'b0};
            end
            else
            begin
                rem_next  = trial[WORD_W-1:0];
                quot_next = {quot_reg[WORD_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // remainder can exceed 64 bits in the shift, so keep carry in trial
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg;

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg)
        else $error("divider not busy after start");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> cnt_reg == 7'd0)
        else $error("divider count nonzero while idle");
`endif

endmodule

// ===== rtl/next_prime_power_multiple_sieve.sv =====
// ----------------------------------------------------------------------------
// next_prime_power_multiple_sieve
// sorted table of (modulus, next multiple) pairs with load and query requests
// ----------------------------------------------------------------------------
// a load divides once, then swaps the new entry down; a query divides for each advanced
//   entry and swaps it up; the 64-step divider and the table's one read port bound the time
// throughput: one request at a time; in_stall is high until the result is taken
// reset: asynchronous, clears entry count, start_value to 1, first_active to 0;
//   table contents are undefined until written, no clearing pass
module next_prime_power_multiple_sieve #(
    parameter int unsigned TABLE_DEPTH = npms_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [63:0] modulus,
    input  logic [63:0] query_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] next_multiple,
    output logic        overflow,
    output logic        table_full
);
    import npms_pkg::*;

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

    logic [2*WORD_W-1:0] mod_mem [TABLE_DEPTH];

    state_t state_reg, state_next;
    logic [WORD_W-1:0]   start_reg;
    logic [ACTIVE_W-1:0] first_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [WORD_W-1:0]   nval_reg, nval_next;
    logic [WORD_W-1:0]   cm_reg, cm_next;     // current entry modulus
    logic [WORD_W-1:0]   cv_reg, cv_next;     // current entry multiple
    logic [WORD_W-1:0]   base_reg, base_next;
    logic [WORD_W-1:0]   prod_reg;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0]    pass_reg, pass_next;
    logic                ovf_reg, ovf_next;
    logic [WORD_W-1:0]   res_reg, res_next;
    logic                full_reg, full_next;
    logic [2*WORD_W-1:0] rd_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [2*WORD_W-1:0] wr_data;
    div_req_t            dreq;
    div_rsp_t            drsp;
    logic [WORD_W-1:0]   lower;
    logic [WORD_W:0]     sum;
    logic [CNT_W-1:0]    first_ext;
    logic [WORD_W-1:0]   nb_mul;

    npms_divider u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (dreq),
        .rsp (drsp)
    );

    assign first_ext = CNT_W'(first_reg);
    assign nb_mul    = rd_reg[WORD_W-1:0];
    assign lower     = base_reg + prod_reg;
    assign sum       = {1'b0, lower} + {1'b0, cm_reg};

    // table: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mod_mem[wr_addr] <= wr_data;
        rd_reg <= mod_mem[rd_addr];
    end

    // quotient times modulus is the dividend less the remainder
    always_ff @(posedge clk)
    begin
        prod_reg <= nval_reg - base_reg - drsp.remainder;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 64'd1;
            first_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_START_VALUE)
                start_reg <= cfg_data;
            else
                first_reg <= cfg_data[ACTIVE_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    if (operation == OP_LOAD)
                        state_next = (count_reg >= CNT_W'(TABLE_DEPTH)) ? ST_DONE
                            : (modulus == '0) ? ST_LOAD_WRITE : ST_LOAD_DIV;
                    else
                        state_next = (first_ext >= count_reg) ? ST_DONE : ST_Q_RD;
                end
            ST_LOAD_DIV:   if (drsp.done) state_next = ST_LOAD_MUL;
            ST_LOAD_MUL:   state_next = ST_LOAD_CHK;
            ST_LOAD_CHK:   state_next = ST_LOAD_WRITE;
            ST_LOAD_WRITE: state_next = (pos_reg == '0) ? ST_DONE : ST_LOAD_RD;
            ST_LOAD_RD:    state_next = ST_LOAD_CMP;
            ST_LOAD_CMP:   state_next = (cv_reg < nb_mul) ? ST_LOAD_WRITE : ST_DONE;
            ST_Q_RD:       state_next = ST_Q_CMP;
            ST_Q_CMP:
                if (nb_mul > nval_reg)                      state_next = ST_DONE;
                else if (pass_reg == '0)                    state_next = ST_DONE;
                else if (rd_reg[2*WORD_W-1:WORD_W] == '0)   state_next = ST_Q_WRITE;
                else                                        state_next = ST_Q_DIV;
            ST_Q_DIV:   if (drsp.done) state_next = ST_Q_MUL;
            ST_Q_MUL:   state_next = ST_Q_ADD;
            ST_Q_ADD:   state_next = ST_Q_WRITE;
            ST_Q_WRITE:
                state_next = (CNT_W'(pos_reg) + 1'b1 >= count_reg) ? ST_Q_RD : ST_Q_RDN;
            ST_Q_RDN:   state_next = ST_Q_CMPN;
            ST_Q_CMPN:  state_next = (cv_reg > nb_mul) ? ST_Q_WRITE : ST_Q_RD;
            ST_DONE:    if (!out_stall) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        nval_next  = nval_reg;
        cm_next    = cm_reg;
        cv_next    = cv_reg;
        base_next  = base_reg;
        pos_next   = pos_reg;
        pass_next  = pass_reg;
        ovf_next   = ovf_reg;
        res_next   = res_reg;
        full_next  = full_reg;
        rd_addr    = pos_reg;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = {cm_reg, cv_reg};
        dreq       = '0;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                begin
                    ovf_next  = 1'b0;
                    full_next = 1'b0;
                    res_next  = '0;
                    nval_next = query_value;
                    if (operation == OP_LOAD)
                    begin
                        cm_next   = modulus;
                        base_next = '0;
                        nval_next = start_reg;
                        pos_next  = IDX_W'(count_reg);
                        if (count_reg >= CNT_W'(TABLE_DEPTH))
                            full_next = 1'b1;
                        else if (modulus == '0)
                        begin
                            cv_next  = MAX_WORD;
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            dreq.start    = 1'b1;
                            dreq.dividend = start_reg;
                            dreq.divisor  = modulus;
                        end
                    end
                    else
                    begin
                        pos_next  = IDX_W'(first_reg);
                        pass_next = count_reg - first_ext;
                    end
                end
            ST_LOAD_CHK, ST_Q_ADD:
                if (sum[WORD_W])
                begin
                    cv_next  = MAX_WORD;
                    ovf_next = 1'b1;
                end
                else
                    cv_next = sum[WORD_W-1:0];
            ST_LOAD_WRITE:
            begin
                wr_en = 1'b1;
                if (pos_reg == IDX_W'(count_reg))
                    res_next = cv_reg;
                if (pos_reg == '0)
                    count_next = count_reg + 1'b1;
                rd_addr = pos_reg - 1'b1;
            end
            ST_LOAD_RD:
                rd_addr = pos_reg - 1'b1;
            ST_LOAD_CMP:
                if (cv_reg < nb_mul)
                begin
                    // swap: neighbor moves up into pos
                    wr_en    = 1'b1;
                    wr_data  = rd_reg;
                    pos_next = pos_reg - 1'b1;
                end
                else
                    count_next = count_reg + 1'b1;
            ST_Q_RD:
                pos_next = IDX_W'(first_reg);
            ST_Q_CMP:
            begin
                cm_next = rd_reg[2*WORD_W-1:WORD_W];
                cv_next = rd_reg[WORD_W-1:0];
                if (rd_reg[WORD_W-1:0] > nval_reg)
                    res_next = rd_reg[WORD_W-1:0];
                else if (pass_reg == '0)
                begin
                    res_next = rd_reg[WORD_W-1:0];
                    ovf_next = 1'b1;
                end
                else
                begin
                    pass_next = pass_reg - 1'b1;
                    base_next = rd_reg[WORD_W-1:0];
                    if (rd_reg[2*WORD_W-1:WORD_W] == '0)
                    begin
                        cv_next  = MAX_WORD;
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        dreq.start    = 1'b1;
                        dreq.dividend = nval_reg - rd_reg[WORD_W-1:0];
                        dreq.divisor  = rd_reg[2*WORD_W-1:WORD_W];
                    end
                end
            end
            ST_Q_WRITE:
            begin
                wr_en   = 1'b1;
                rd_addr = pos_reg + 1'b1;
            end
            ST_Q_RDN:
                rd_addr = pos_reg + 1'b1;
            ST_Q_CMPN:
                if (cv_reg > nb_mul)
                begin
                    wr_en    = 1'b1;
                    wr_data  = rd_reg;
                    pos_next = pos_reg + 1'b1;
                end
            default: ;
        endcase
        if (state_reg == ST_Q_RD)
            rd_addr = IDX_W'(first_reg);
        else if (state_reg == ST_Q_CMPN && !(cv_reg > nb_mul))
            rd_addr = IDX_W'(first_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nval_reg <= nval_next;
        cm_reg   <= cm_next;
        cv_reg   <= cv_next;
        base_reg <= base_next;
        pos_reg  <= pos_next;
        pass_reg <= pass_next;
        ovf_reg  <= ovf_next;
        res_reg  <= res_next;
        full_reg <= full_next;
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = (state_reg == ST_DONE);
    assign next_multiple = res_reg;
    assign overflow      = ovf_reg;
    assign table_full    = full_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond depth");
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && table_full |-> next_multiple == '0 && !overflow)
        else $error("refused load with a nonzero result");
    a_count_only_load: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> $past(state_reg) == ST_LOAD_WRITE
            || $past(state_reg) == ST_LOAD_CMP)
        else $error("entry count moved outside a load");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(next_multiple))
        else $error("result dropped while stalled");
`endif

endmodule
